// File: rtl/core/aes128_block_encrypt_core_defines.svh
// Assertion helpers used by the checker file of this block.
`ifndef AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH

// Implication that is ignored while reset is asserted.
`define AESENC_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication that is also checked across reset.
`define AESENC_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/aesenc_pkg.sv
package aesenc_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned RCNT_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(1);

    typedef logic [127:0] block_t;
    typedef block_t [NUM_ROUNDS:0] rkeys_t;

    localparam logic [0:255][7:0] SBOX = {
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Byte i of a block sits in bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
        return b[127 - 8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes followed by ShiftRows.
    function automatic block_t sub_shift(input block_t s);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
            end
        end
        return t;
    endfunction

    function automatic block_t mix_cols(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            d0 = xtime(a0);
            d1 = xtime(a1);
            d2 = xtime(a2);
            d3 = xtime(a3);
            t[127 - 32*c -: 8]  = d0 ^ d1 ^ a1 ^ a2 ^ a3;
            t[119 - 32*c -: 8]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
            t[111 - 32*c -: 8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
            t[103 - 32*c -: 8]  = d0 ^ a0 ^ a1 ^ a2 ^ d3;
        end
        return t;
    endfunction

    function automatic logic [7:0] rcon(input logic [RCNT_W-1:0] step);
        logic [7:0] rc;
        unique case (step)
            4'd0:    rc = 8'h01;
            4'd1:    rc = 8'h02;
            4'd2:    rc = 8'h04;
            4'd3:    rc = 8'h08;
            4'd4:    rc = 8'h10;
            4'd5:    rc = 8'h20;
            4'd6:    rc = 8'h40;
            4'd7:    rc = 8'h80;
            4'd8:    rc = 8'h1b;
            4'd9:    rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // One step of the key schedule: round key r to round key r+1.
    function automatic block_t key_step(input block_t k, input logic [7:0] rc);
        logic [31:0] t, w0, w1, w2, w3;
        t  = {SBOX[k[23:16]], SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        t  = t ^ {rc, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// File: rtl/core/aesenc_keyexp.sv
// Holds the cipher key and expands it into the round keys, one per cycle.
module aesenc_keyexp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aesenc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                         cfg_data,
    output aesenc_pkg::rkeys_t                  round_keys,
    output logic                                key_ready
);

    logic [63:0]                      key_high_reg, key_high_next;
    logic [63:0]                      key_low_reg, key_low_next;
    aesenc_pkg::block_t               cur_reg;
    aesenc_pkg::rkeys_t               rk_reg;
    logic [aesenc_pkg::RCNT_W-1:0]    cnt_reg;
    logic                             busy_reg;
    logic                             key_write;

    assign cfg_ready = 1'b1;

    always_comb begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        key_write     = 1'b0;
        priority if (cfg_valid && cfg_index == aesenc_pkg::REG_KEY_HIGH) begin
            key_high_next = cfg_data;
            key_write     = 1'b1;
        end else if (cfg_valid && cfg_index == aesenc_pkg::REG_KEY_LOW) begin
            key_low_next = cfg_data;
            key_write    = 1'b1;
        end else begin
            key_write = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            cur_reg      <= '0;
            cnt_reg      <= '0;
            busy_reg     <= 1'b1;
        end else if (key_write) begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
            cur_reg      <= {key_high_next, key_low_next};
            cnt_reg      <= '0;
            busy_reg     <= 1'b1;
        end else if (busy_reg) begin
            cur_reg <= aesenc_pkg::key_step(cur_reg, aesenc_pkg::rcon(cnt_reg));
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == aesenc_pkg::RCNT_W'(aesenc_pkg::NUM_ROUNDS)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            rk_reg[cnt_reg] <= cur_reg;
        end
    end

    assign round_keys = rk_reg;
    assign key_ready  = !busy_reg;

endmodule

// File: rtl/core/aesenc_round.sv
// One cipher round with its own pipeline register and valid bit.
module aesenc_round (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  final_round,
    input  aesenc_pkg::block_t    round_key,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  aesenc_pkg::block_t    in_state,
    output logic                  out_valid,
    input  logic                  out_ready,
    output aesenc_pkg::block_t    out_state
);

    logic                  v_reg;
    aesenc_pkg::block_t    st_reg, st_next, shifted;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        shifted = aesenc_pkg::sub_shift(in_state);
        st_next = (final_round ? shifted : aesenc_pkg::mix_cols(shifted)) ^ round_key;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = v_reg;
    assign out_state = st_reg;

endmodule

// File: rtl/core/aes128_block_encrypt_core.sv
// AES-128 block encryption in ECB mode, one 128-bit block per request.
// Input stream: s_tdata carries block_high in bits [63:0] and block_low in
// bits [127:64]; byte 0 of the block is the top byte of block_high.
// Output stream: m_tdata carries cipher_high and cipher_low the same way.
// Configuration: cfg_index 0 writes key_high, index 1 writes key_low; any
// other index is ignored. A write restarts the key expansion; s_tready
// stays low until it completes. Keys must be changed only while no block
// is in flight; the core itself does not enforce this. The edge that
// accepts an input request loads the AddRoundKey register, and each of
// the ten rounds adds one register behind it; m_tvalid rises once the
// block sits in the register of the last round. Throughput is one block
// per cycle while m_tready is high and no key expansion runs, set by the
// unrolled round pipeline. After reset the all-zero key is expanded, so
// s_tready rises once that expansion completes. When the receiver stalls,
// stages hold their contents and empty stages further up still fill, so
// bubbles are squeezed out before the input side is held off.
module aes128_block_encrypt_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [127:0]                        s_tdata,   // block_high, block_low
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [127:0]                        m_tdata,   // cipher_high, cipher_low
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aesenc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                         cfg_data
);

    aesenc_pkg::rkeys_t    round_keys;
    logic                  key_ready;

    // Stage valid, ready and state along the pipeline; index 0 is the
    // AddRoundKey register, index r the output of round r.
    logic [aesenc_pkg::NUM_ROUNDS:0]                  stg_valid;
    logic [aesenc_pkg::NUM_ROUNDS:0]                  stg_ready;
    aesenc_pkg::block_t [aesenc_pkg::NUM_ROUNDS:0]    stg_state;

    logic                  v0_reg;
    aesenc_pkg::block_t    s0_reg;
    logic                  in_ready0;

    aesenc_keyexp u_keyexp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .round_keys (round_keys),
        .key_ready  (key_ready)
    );

    // Initial AddRoundKey stage. Fields are swapped into byte order here.
    assign in_ready0 = !v0_reg || stg_ready[0];
    assign s_tready  = in_ready0 && key_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (in_ready0) begin
            v0_reg <= s_tvalid && key_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s0_reg <= {s_tdata[63:0], s_tdata[127:64]} ^ round_keys[0];
        end
    end

    assign stg_valid[0] = v0_reg;
    assign stg_state[0] = s0_reg;

    for (genvar r = 1; r <= aesenc_pkg::NUM_ROUNDS; r++) begin : g_round
        aesenc_round u_round (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .final_round (r == aesenc_pkg::NUM_ROUNDS),
            .round_key   (round_keys[r]),
            .in_valid    (stg_valid[r-1]),
            .in_ready    (stg_ready[r-1]),
            .in_state    (stg_state[r-1]),
            .out_valid   (stg_valid[r]),
            .out_ready   (stg_ready[r]),
            .out_state   (stg_state[r])
        );
    end

    assign stg_ready[aesenc_pkg::NUM_ROUNDS] = m_tready;
    assign m_tvalid = stg_valid[aesenc_pkg::NUM_ROUNDS];
    assign m_tdata  = {stg_state[aesenc_pkg::NUM_ROUNDS][63:0],
                       stg_state[aesenc_pkg::NUM_ROUNDS][127:64]};

endmodule

// File: rtl/core/aesenc_checker.sv
`include "aes128_block_encrypt_core_defines.svh"

module aesenc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [127:0]                        m_tdata,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [aesenc_pkg::CFG_IDX_W-1:0]    cfg_index
);

    logic key_write;

    assign key_write = cfg_valid && cfg_ready &&
                       (cfg_index == aesenc_pkg::REG_KEY_HIGH ||
                        cfg_index == aesenc_pkg::REG_KEY_LOW);

    // A stalled result stays offered and unchanged.
    `AESENC_ASSERT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `AESENC_ASSERT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    // Key expansion blocks input right after reset and after a key write.
    `AESENC_ASSERT_RST(a_rst_block, !aresetn, !s_tready)
    `AESENC_ASSERT(a_key_block, key_write, !s_tready)

endmodule

bind aes128_block_encrypt_core aesenc_checker u_aesenc_checker (.*);
